// ===== rtl/dns_query_packet_builder_defines.svh =====
// ----------------------------------------------------------------------------
// dns query packet builder assertion macros
// shared property wrappers for the port checker
// ----------------------------------------------------------------------------
`ifndef DNS_QUERY_PACKET_BUILDER_DEFINES_SVH
`define DNS_QUERY_PACKET_BUILDER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define DQPB_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dqpb checker: implication failed");

// next-cycle implication, sampled on clk, off during reset
`define DQPB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dqpb checker: next-cycle implication failed");

`endif

// ===== rtl/dqpb_pkg.sv =====
// ----------------------------------------------------------------------------
// dqpb_pkg
// shared constants and types of the dns query packet builder
// ----------------------------------------------------------------------------
package dqpb_pkg;

  localparam int MAX_LABEL   = 63;
  localparam int LBL_W       = $clog2(MAX_LABEL + 1);
  localparam int STORE_DEPTH = 2 ** LBL_W;
  localparam int CNT_W       = (LBL_W > 4) ? LBL_W : 4;
  localparam int HDR_BYTES   = 12;
  localparam int TAIL_BYTES  = 4;

  localparam logic [7:0]  SEPARATOR    = 8'd46;
  localparam logic [7:0]  END_CHAR     = 8'd0;
  localparam logic [15:0] QD_COUNT     = 16'd1;
  localparam logic [15:0] FLAGS_RESET  = 16'h0100;
  localparam logic [15:0] QTYPE_RESET  = 16'd1;
  localparam logic [15:0] QCLASS_RESET = 16'd1;

  typedef enum logic [1:0] {
    CFG_FLAGS  = 2'd0,
    CFG_QTYPE  = 2'd1,
    CFG_QCLASS = 2'd2
  } dqpb_cfg_idx_t;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_HDR  = 6'b000010,
    ST_LEN  = 6'b000100,
    ST_DATA = 6'b001000,
    ST_ROOT = 6'b010000,
    ST_TAIL = 6'b100000
  } dqpb_state_t;

  typedef enum logic [2:0] {
    SEL_HDR  = 3'd0,
    SEL_LEN  = 3'd1,
    SEL_DATA = 3'd2,
    SEL_ROOT = 3'd3,
    SEL_TAIL = 3'd4
  } dqpb_sel_t;

  typedef struct packed {
    logic      accept;
    logic      emit;
    dqpb_sel_t sel;
    logic      step_last;
    logic      step_pen;
    logic      pkt_end;
    logic      cnt_clr;
    logic      cnt_inc;
    logic      clr_label;
    logic      end_pkt;
  } dqpb_cmd_t;

  typedef struct packed {
    logic in_name;
    logic lbl_zero;
    logic hdr_last;
    logic data_last;
    logic data_pen;
    logic tail_last;
    logic ch_end;
    logic ch_sep;
  } dqpb_sts_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       step_last;
    logic       step_pen;
    logic       pkt_end;
    logic       ovf;
  } dqpb_byte_t;

endpackage

// ===== rtl/dqpb_ctrl.sv =====
// ----------------------------------------------------------------------------
// dqpb_ctrl
// sequencer that walks header, label replay, root and tail bytes
// ----------------------------------------------------------------------------
module dqpb_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  dqpb_pkg::dqpb_sts_t sts,
  input  logic                out_free,
  output dqpb_pkg::dqpb_cmd_t cmd
);

  dqpb_pkg::dqpb_state_t state_r, state_nxt;
  logic end_r, end_nxt;
  logic sep_r, sep_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dqpb_pkg::ST_IDLE;
      end_r   <= 1'b0;
      sep_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      end_r   <= end_nxt;
      sep_r   <= sep_nxt;
    end
  end

  assign in_stall = (state_r != dqpb_pkg::ST_IDLE);

  always_comb begin
    cmd       = '0;
    cmd.sel   = dqpb_pkg::SEL_HDR;
    state_nxt = state_r;
    end_nxt   = end_r;
    sep_nxt   = sep_r;
    unique case (state_r)
      dqpb_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          end_nxt    = sts.ch_end;
          sep_nxt    = sts.ch_sep;
          if (!sts.in_name) begin
            state_nxt   = dqpb_pkg::ST_HDR;
            cmd.cnt_clr = 1'b1;
          end else if (sts.ch_end) begin
            state_nxt   = sts.lbl_zero ? dqpb_pkg::ST_ROOT : dqpb_pkg::ST_LEN;
            cmd.cnt_clr = 1'b1;
          end else if (sts.ch_sep) begin
            state_nxt   = dqpb_pkg::ST_LEN;
            cmd.cnt_clr = 1'b1;
          end
        end
      end
      dqpb_pkg::ST_HDR: begin
        if (out_free) begin
          cmd.emit = 1'b1;
          cmd.sel  = dqpb_pkg::SEL_HDR;
          if (sts.hdr_last) begin
            cmd.cnt_clr   = 1'b1;
            // a plain character ends its step with the header
            cmd.step_last = !end_r && !sep_r;
            // a separator adds only the empty length byte after it
            cmd.step_pen  = sep_r;
            if (end_r) begin
              state_nxt = sts.lbl_zero ? dqpb_pkg::ST_ROOT : dqpb_pkg::ST_LEN;
            end else if (sep_r) begin
              state_nxt = dqpb_pkg::ST_LEN;
            end else begin
              state_nxt = dqpb_pkg::ST_IDLE;
            end
          end else begin
            cmd.cnt_inc = 1'b1;
          end
        end
      end
      dqpb_pkg::ST_LEN: begin
        if (out_free) begin
          cmd.emit    = 1'b1;
          cmd.sel     = dqpb_pkg::SEL_LEN;
          cmd.cnt_clr = 1'b1;
          if (sts.lbl_zero) begin
            // empty inner label: lone zero length byte
            cmd.step_last = sep_r;
            cmd.clr_label = 1'b1;
            state_nxt     = end_r ? dqpb_pkg::ST_ROOT : dqpb_pkg::ST_IDLE;
          end else begin
            // counter is zero here, so data_last means a one-character label
            cmd.step_pen = sep_r && sts.data_last;
            state_nxt    = dqpb_pkg::ST_DATA;
          end
        end
      end
      dqpb_pkg::ST_DATA: begin
        if (out_free) begin
          cmd.emit = 1'b1;
          cmd.sel  = dqpb_pkg::SEL_DATA;
          if (sts.data_last) begin
            cmd.step_last = sep_r;
            cmd.clr_label = 1'b1;
            cmd.cnt_clr   = 1'b1;
            state_nxt     = end_r ? dqpb_pkg::ST_ROOT : dqpb_pkg::ST_IDLE;
          end else begin
            cmd.step_pen = sep_r && sts.data_pen;
            cmd.cnt_inc  = 1'b1;
          end
        end
      end
      dqpb_pkg::ST_ROOT: begin
        if (out_free) begin
          cmd.emit    = 1'b1;
          cmd.sel     = dqpb_pkg::SEL_ROOT;
          cmd.cnt_clr = 1'b1;
          state_nxt   = dqpb_pkg::ST_TAIL;
        end
      end
      dqpb_pkg::ST_TAIL: begin
        if (out_free) begin
          cmd.emit = 1'b1;
          cmd.sel  = dqpb_pkg::SEL_TAIL;
          if (sts.tail_last) begin
            cmd.step_last = 1'b1;
            cmd.pkt_end   = 1'b1;
            cmd.end_pkt   = 1'b1;
            cmd.cnt_clr   = 1'b1;
            state_nxt     = dqpb_pkg::ST_IDLE;
          end else begin
            cmd.cnt_inc = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = dqpb_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/dqpb_datapath.sv =====
// ----------------------------------------------------------------------------
// dqpb_datapath
// name state, label buffer, config registers and packet byte select
// ----------------------------------------------------------------------------
module dqpb_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [7:0]           in_ch,
  input  logic                 cfg_valid,
  input  logic [1:0]           cfg_index,
  input  logic [15:0]          cfg_data,
  input  dqpb_pkg::dqpb_cmd_t  cmd,
  output dqpb_pkg::dqpb_sts_t  sts,
  output dqpb_pkg::dqpb_byte_t byte_o
);

  logic [15:0] flags_r, qtype_r, qclass_r;
  logic [15:0] req_id_r;
  logic        in_name_r;
  logic        ovf_r;
  logic [dqpb_pkg::LBL_W-1:0] lbl_cnt_r;
  logic [dqpb_pkg::CNT_W-1:0] cnt_r, cnt_nxt;

  logic [7:0] store_mem [dqpb_pkg::STORE_DEPTH];
  logic [7:0] rd_r;

  logic        ch_end, ch_sep, ch_plain, lbl_full, store_we;
  logic [127:0] hdr_vec;
  logic [31:0]  tail_vec;
  logic [7:0]   byte_sel;

  assign ch_end   = (in_ch == dqpb_pkg::END_CHAR);
  assign ch_sep   = (in_ch == dqpb_pkg::SEPARATOR);
  assign ch_plain = !ch_end && !ch_sep;
  assign lbl_full = (lbl_cnt_r == dqpb_pkg::LBL_W'(dqpb_pkg::MAX_LABEL));
  assign store_we = cmd.accept && ch_plain && !lbl_full;

  always_comb begin
    if (cmd.cnt_clr) begin
      cnt_nxt = '0;
    end else if (cmd.cnt_inc) begin
      cnt_nxt = cnt_r + 1'b1;
    end else begin
      cnt_nxt = cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r   <= dqpb_pkg::FLAGS_RESET;
      qtype_r   <= dqpb_pkg::QTYPE_RESET;
      qclass_r  <= dqpb_pkg::QCLASS_RESET;
      req_id_r  <= '0;
      in_name_r <= 1'b0;
      ovf_r     <= 1'b0;
      lbl_cnt_r <= '0;
      cnt_r     <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (cfg_valid) begin
        if (cfg_index == dqpb_pkg::CFG_FLAGS) begin
          flags_r <= cfg_data;
        end else if (cfg_index == dqpb_pkg::CFG_QTYPE) begin
          qtype_r <= cfg_data;
        end else if (cfg_index == dqpb_pkg::CFG_QCLASS) begin
          qclass_r <= cfg_data;
        end
      end
      if (cmd.accept) begin
        if (!in_name_r) begin
          in_name_r <= 1'b1;
          req_id_r  <= req_id_r + 16'd1;
        end
        if (ch_plain && lbl_full) begin
          ovf_r <= 1'b1;
        end
      end
      if (cmd.clr_label || cmd.end_pkt) begin
        lbl_cnt_r <= '0;
      end else if (store_we) begin
        lbl_cnt_r <= lbl_cnt_r + 1'b1;
      end
      if (cmd.end_pkt) begin
        in_name_r <= 1'b0;
        ovf_r     <= 1'b0;
      end
    end
  end

  // label buffer, read one entry ahead of replay
  always_ff @(posedge clk) begin
    if (store_we) begin
      store_mem[lbl_cnt_r] <= in_ch;
    end
    rd_r <= store_mem[cnt_nxt[dqpb_pkg::LBL_W-1:0]];
  end

  // byte k of the header sits at bits [8k+7:8k]
  assign hdr_vec  = {80'd0, dqpb_pkg::QD_COUNT[7:0], dqpb_pkg::QD_COUNT[15:8],
                     flags_r[7:0], flags_r[15:8], req_id_r[7:0], req_id_r[15:8]};
  assign tail_vec = {qclass_r[7:0], qclass_r[15:8], qtype_r[7:0], qtype_r[15:8]};

  always_comb begin
    unique case (cmd.sel)
      dqpb_pkg::SEL_HDR:  byte_sel = hdr_vec[{cnt_r[3:0], 3'b000} +: 8];
      dqpb_pkg::SEL_LEN:  byte_sel = 8'(lbl_cnt_r);
      dqpb_pkg::SEL_DATA: byte_sel = rd_r;
      dqpb_pkg::SEL_TAIL: byte_sel = tail_vec[{cnt_r[1:0], 3'b000} +: 8];
      default:            byte_sel = 8'd0;
    endcase
  end

  assign byte_o.valid     = cmd.emit;
  assign byte_o.data      = byte_sel;
  assign byte_o.step_last = cmd.step_last;
  assign byte_o.step_pen  = cmd.step_pen;
  assign byte_o.pkt_end   = cmd.pkt_end;
  assign byte_o.ovf       = ovf_r;

  assign sts.in_name   = in_name_r;
  assign sts.lbl_zero  = (lbl_cnt_r == '0);
  assign sts.hdr_last  = (cnt_r == dqpb_pkg::CNT_W'(dqpb_pkg::HDR_BYTES - 1));
  assign sts.tail_last = (cnt_r == dqpb_pkg::CNT_W'(dqpb_pkg::TAIL_BYTES - 1));
  assign sts.data_last = ((cnt_r + 1'b1) == dqpb_pkg::CNT_W'(lbl_cnt_r));
  assign sts.data_pen  = ((cnt_r + 2'd2) == dqpb_pkg::CNT_W'(lbl_cnt_r));
  assign sts.ch_end    = ch_end;
  assign sts.ch_sep    = ch_sep;

endmodule

// ===== rtl/dqpb_pack.sv =====
// ----------------------------------------------------------------------------
// dqpb_pack
// pairs the byte stream into results and holds the output register
// ----------------------------------------------------------------------------
module dqpb_pack (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dqpb_pkg::dqpb_byte_t byte_i,
  output logic                 out_free,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           out_byte_first,
  output logic [7:0]           out_byte_second,
  output logic [1:0]           out_byte_count,
  output logic                 out_packet_end,
  output logic                 out_run_end,
  output logic                 out_label_overflow
);

  logic       held_v_r;
  logic [7:0] held_r;
  logic       out_valid_r;
  logic [7:0] first_r, second_r;
  logic [1:0] count_r;
  logic       pe_r, run_r, ovf_r;
  logic       taken;

  assign taken    = out_valid_r && !out_stall;
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (byte_i.valid) begin
      if (held_v_r) begin
        out_valid_r <= 1'b1;
        held_v_r    <= 1'b0;
      end else if (byte_i.pkt_end) begin
        out_valid_r <= 1'b1;
      end else begin
        // odd byte waits for its partner, maybe from the next request
        held_v_r <= 1'b1;
        if (taken) begin
          out_valid_r <= 1'b0;
        end
      end
    end else if (taken) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_i.valid) begin
      held_r <= byte_i.data;
      if (held_v_r) begin
        first_r  <= held_r;
        second_r <= byte_i.data;
        count_r  <= 2'd2;
        pe_r     <= byte_i.pkt_end;
        // the lone byte after a penultimate pair is held, so this pair closes the request
        run_r    <= byte_i.step_last || byte_i.step_pen;
        ovf_r    <= byte_i.ovf;
      end else if (byte_i.pkt_end) begin
        first_r  <= byte_i.data;
        second_r <= 8'd0;
        count_r  <= 2'd1;
        pe_r     <= 1'b1;
        run_r    <= 1'b1;
        ovf_r    <= byte_i.ovf;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_byte_first     = first_r;
  assign out_byte_second    = second_r;
  assign out_byte_count     = count_r;
  assign out_packet_end     = pe_r;
  assign out_run_end        = run_r;
  assign out_label_overflow = ovf_r;

endmodule

// ===== rtl/dns_query_packet_builder.sv =====
// ----------------------------------------------------------------------------
// dns_query_packet_builder
// builds a dns standard query from a host name fed one character a request
// ----------------------------------------------------------------------------
// Flow: a label character gives no result unless it is the first of a name.
// Packet bytes leave the sequencer at one byte per cycle while the output
// register can take them; results carry two bytes, or one when that byte
// closes a packet. The first character of a name sends the 12 header bytes; a
// '.' sends the length byte and then the buffered label characters, replayed
// from the label buffer; the end character adds that flush and the root zero,
// QTYPE and QCLASS. The input stalls while the sequencer is producing bytes; a
// full output register that is stalled holds the sequencer, while a plain
// label character is still taken. An odd byte left at the end of a request
// inside a name is held and leads the next request's output. Config writes are
// always ready and are used by the next bytes that read them.
// ----------------------------------------------------------------------------
module dns_query_packet_builder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_ch,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte_first,
  output logic [7:0]  out_byte_second,
  output logic [1:0]  out_byte_count,
  output logic        out_packet_end,
  output logic        out_run_end,
  output logic        out_label_overflow,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  dqpb_pkg::dqpb_cmd_t  cmd;
  dqpb_pkg::dqpb_sts_t  sts;
  dqpb_pkg::dqpb_byte_t byte_s;
  logic                 out_free;

  assign cfg_ready = 1'b1;

  dqpb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .out_free (out_free),
    .cmd      (cmd)
  );

  dqpb_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .byte_o    (byte_s)
  );

  dqpb_pack u_pack (
    .clk                (clk),
    .rst_n              (rst_n),
    .byte_i             (byte_s),
    .out_free           (out_free),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_byte_first     (out_byte_first),
    .out_byte_second    (out_byte_second),
    .out_byte_count     (out_byte_count),
    .out_packet_end     (out_packet_end),
    .out_run_end        (out_run_end),
    .out_label_overflow (out_label_overflow)
  );

endmodule

// ===== rtl/dqpb_checker.sv =====
// ----------------------------------------------------------------------------
// dqpb_checker
// port-level checks on the result channel of the packet builder
// ----------------------------------------------------------------------------
`include "dns_query_packet_builder_defines.svh"

module dqpb_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte_second,
  input logic [1:0] out_byte_count,
  input logic       out_packet_end,
  input logic       out_run_end
);

  // a single-byte result only closes a packet
  `DQPB_ASSERT_IMPL(a_single_ends_pkt, out_valid && out_byte_count == 2'd1, out_packet_end)
  `DQPB_ASSERT_IMPL(a_single_pad_zero, out_valid && out_byte_count == 2'd1, out_byte_second == 8'd0)
  // the packet end is always the last result of its request
  `DQPB_ASSERT_IMPL(a_end_is_run_end, out_valid && out_packet_end, out_run_end)
  `DQPB_ASSERT_NEXT(a_stall_holds, out_valid && out_stall, out_valid)

endmodule

bind dns_query_packet_builder dqpb_checker u_dqpb_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_byte_second (out_byte_second),
  .out_byte_count  (out_byte_count),
  .out_packet_end  (out_packet_end),
  .out_run_end     (out_run_end)
);

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the dns query packet builder: host names go in one
// character per request, and every output word is compared with a built-in
// encoder that tracks header id, label buffer, held odd byte and overflow
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CFG_SPARE       = 2'd3;
  localparam int         DRAIN_CYCLES    = 20;
  localparam int         WATCHDOG_CYCLES = 2000;

  typedef struct packed {
    logic [7:0] first;
    logic [7:0] second;
    logic [1:0] count;
    logic       pkt_end;
    logic       run_end;
    logic       ovf;
  } query_word_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_ch;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_byte_first;
  logic [7:0]  out_byte_second;
  logic [1:0]  out_byte_count;
  logic        out_packet_end;
  logic        out_run_end;
  logic        out_label_overflow;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  // encoder state mirrored from the block
  logic [15:0] flags_reg;
  logic [15:0] qtype_reg;
  logic [15:0] qclass_reg;
  logic [15:0] msg_id;
  logic        pkt_open;
  logic [7:0]  label_buf [dqpb_pkg::STORE_DEPTH];
  int          label_len;
  logic [7:0]  held_byte;
  logic        held_valid;
  logic        ovf_flag;
  logic [7:0]  pkt_bytes [$];

  query_word_t expected_words [$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int error_count    = 0;
  int chars_sent     = 0;
  int names_sent     = 0;
  int words_checked  = 0;
  int reg_writes     = 0;
  int idle_cycles    = 0;

  dns_query_packet_builder DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_ch              (in_ch),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_byte_first     (out_byte_first),
    .out_byte_second    (out_byte_second),
    .out_byte_count     (out_byte_count),
    .out_packet_end     (out_packet_end),
    .out_run_end        (out_run_end),
    .out_label_overflow (out_label_overflow),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void put_word(input logic [15:0] w);
    pkt_bytes.push_back(w[15:8]);
    pkt_bytes.push_back(w[7:0]);
  endfunction

  function automatic void flush_label();
    pkt_bytes.push_back(8'(label_len));
    for (int i = 0; i < label_len; i++) pkt_bytes.push_back(label_buf[i]);
    label_len = 0;
  endfunction

  // encode one accepted character into the output words it causes
  function automatic void encode_char(input logic [7:0] ch);
    logic        ends;
    logic        ovf;
    int          nbytes;
    query_word_t w;
    pkt_bytes.delete();
    ends = 1'b0;
    if (held_valid) pkt_bytes.push_back(held_byte);
    held_valid = 1'b0;
    held_byte  = 8'd0;
    if (!pkt_open) begin
      pkt_open = 1'b1;
      msg_id   = msg_id + 16'd1;
      put_word(msg_id);
      put_word(flags_reg);
      put_word(dqpb_pkg::QD_COUNT);
      put_word(16'd0);
      put_word(16'd0);
      put_word(16'd0);
    end
    if (ch == dqpb_pkg::END_CHAR) begin
      // a name ending in a dot has nothing buffered, so only the root zero
      if (label_len != 0) flush_label();
      pkt_bytes.push_back(8'd0);
      put_word(qtype_reg);
      put_word(qclass_reg);
      ends = 1'b1;
    end else if (ch == dqpb_pkg::SEPARATOR) begin
      flush_label();
    end else if (label_len < dqpb_pkg::MAX_LABEL) begin
      label_buf[label_len] = ch;
      label_len++;
    end else begin
      ovf_flag = 1'b1;
    end
    ovf = ovf_flag;
    // inside a name an odd last byte waits for the next request
    if (!ends && (pkt_bytes.size() % 2 == 1)) begin
      held_byte  = pkt_bytes.pop_back();
      held_valid = 1'b1;
    end
    nbytes = pkt_bytes.size();
    for (int pos = 0; pos < nbytes; pos += 2) begin
      w.first   = pkt_bytes[pos];
      w.second  = (pos + 1 < nbytes) ? pkt_bytes[pos + 1] : 8'd0;
      w.count   = (pos + 1 < nbytes) ? 2'd2 : 2'd1;
      w.run_end = (pos + 2 >= nbytes);
      w.pkt_end = ends && w.run_end;
      w.ovf     = ovf;
      expected_words.push_back(w);
    end
    if (ends) begin
      pkt_open  = 1'b0;
      label_len = 0;
      ovf_flag  = 1'b0;
    end
  endfunction

  function automatic logic [7:0] random_label_char();
    logic [7:0] c;
    c = 8'($urandom_range(1, 255));
    if (c == dqpb_pkg::SEPARATOR) c = 8'h2f;
    return c;
  endfunction

  task automatic check_field(input string field, input logic [15:0] expv,
                             input logic [15:0] actv);
    if (expv !== actv) begin
      $error("%s mismatch: expected %0h, actual %0h", field, expv, actv);
      error_count++;
    end
  endtask

  // output side: compare accepted words, then pick the next stall
  always @(posedge clk) begin : word_check
    query_word_t exp_w;
    if (rst_n && out_valid && !out_stall) begin
      words_checked++;
      if (expected_words.size() == 0) begin
        $error("output word with nothing expected: first %0h second %0h count %0d",
               out_byte_first, out_byte_second, out_byte_count);
        error_count++;
      end else begin
        exp_w = expected_words.pop_front();
        check_field("byte_first", 16'(exp_w.first), 16'(out_byte_first));
        if (exp_w.count == 2'd2) begin
          check_field("byte_second", 16'(exp_w.second), 16'(out_byte_second));
        end
        check_field("byte_count", 16'(exp_w.count), 16'(out_byte_count));
        check_field("packet_end", 16'(exp_w.pkt_end), 16'(out_packet_end));
        check_field("run_end", 16'(exp_w.run_end), 16'(out_run_end));
        check_field("label_overflow", 16'(exp_w.ovf), 16'(out_label_overflow));
      end
    end
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_CYCLES) begin
      $error("no progress for %0d cycles, %0d words outstanding",
             idle_cycles, expected_words.size());
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // valid stays high after a request; an idle gap in the next call or a wait lowers it
  task automatic send_char(input logic [7:0] ch);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_ch    <= ch;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    encode_char(ch);
    chars_sent++;
    if (ch == dqpb_pkg::END_CHAR) names_sent++;
  endtask

  task automatic wait_for_words();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_words.size() != 0);
  endtask

  task automatic settle();
    wait_for_words();
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // writes every register plus the unused index, valid held across the burst
  task automatic program_regs(input logic [15:0] flags_val, input logic [15:0] qtype_val,
                              input logic [15:0] qclass_val);
    logic [1:0]  idx [4];
    logic [15:0] val [4];
    idx = '{dqpb_pkg::CFG_FLAGS, dqpb_pkg::CFG_QTYPE, dqpb_pkg::CFG_QCLASS, CFG_SPARE};
    val = '{flags_val, qtype_val, qclass_val, 16'($urandom)};
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      case (idx[i])
        dqpb_pkg::CFG_FLAGS:  flags_reg  = val[i];
        dqpb_pkg::CFG_QTYPE:  qtype_reg  = val[i];
        dqpb_pkg::CFG_QCLASS: qclass_reg = val[i];
        default: ;
      endcase
      reg_writes++;
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic send_random_name(input bit pause_early);
    int n_labels;
    int len;
    if (pause_early) begin
      send_char(random_label_char());
      wait_for_words();
    end
    n_labels = $urandom_range(0, 4);
    for (int l = 0; l < n_labels; l++) begin
      // empty labels give leading or doubled dots
      len = ($urandom_range(7) == 0) ? 0 : $urandom_range(1, 12);
      for (int k = 0; k < len; k++) send_char(random_label_char());
      if (l != n_labels - 1 || $urandom_range(4) == 0) send_char(dqpb_pkg::SEPARATOR);
    end
    send_char(dqpb_pkg::END_CHAR);
  endtask

  task automatic test_reset_defaults();
    logic [7:0] chars [$];
    // root only, leading dot, trailing dot, doubled dots, odd byte counts
    chars = '{dqpb_pkg::END_CHAR,
              dqpb_pkg::SEPARATOR, dqpb_pkg::END_CHAR,
              8'hff, dqpb_pkg::SEPARATOR, dqpb_pkg::END_CHAR,
              dqpb_pkg::SEPARATOR, dqpb_pkg::SEPARATOR, 8'h01, dqpb_pkg::END_CHAR,
              8'h80, 8'h7f, 8'h2d, 8'h2f, dqpb_pkg::SEPARATOR, 8'h41,
              dqpb_pkg::END_CHAR};
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    foreach (chars[i]) send_char(chars[i]);
    settle();
  endtask

  task automatic test_register_extremes();
    program_regs(16'h0000, 16'h0000, 16'h0000);
    send_random_name(1'b0);
    send_random_name(1'b0);
    settle();
    program_regs(16'hffff, 16'hffff, 16'hffff);
    send_random_name(1'b0);
    send_random_name(1'b0);
    settle();
    program_regs(16'h8001, 16'h00ff, 16'hff00);
    send_random_name(1'b0);
    settle();
  endtask

  // labels at and past the limit, and a name over 255 bytes
  task automatic test_label_limit();
    int lens [4];
    lens           = '{dqpb_pkg::MAX_LABEL, dqpb_pkg::MAX_LABEL + 1,
                       dqpb_pkg::MAX_LABEL + 2, dqpb_pkg::MAX_LABEL};
    send_idle_pct  = 0;
    recv_stall_pct = 67;
    foreach (lens[l]) begin
      for (int k = 0; k < lens[l]; k++) send_char(random_label_char());
      if (l != 3) send_char(dqpb_pkg::SEPARATOR);
    end
    send_char(dqpb_pkg::END_CHAR);
    // overflow flag must be gone in the next packet
    send_random_name(1'b0);
    settle();
  endtask

  task automatic test_random_traffic(input int send_pct, input int stall_pct,
                                     input int budget);
    int first_char;
    program_regs(16'($urandom), 16'($urandom), 16'($urandom));
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    first_char     = chars_sent;
    send_random_name(1'b1);
    while (chars_sent - first_char < budget) send_random_name(1'b0);
    settle();
  endtask

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_ch      = 8'd0;
    cfg_valid  = 1'b0;
    cfg_index  = dqpb_pkg::CFG_FLAGS;
    cfg_data   = 16'd0;
    flags_reg  = dqpb_pkg::FLAGS_RESET;
    qtype_reg  = dqpb_pkg::QTYPE_RESET;
    qclass_reg = dqpb_pkg::QCLASS_RESET;
    msg_id     = 16'd0;
    pkt_open   = 1'b0;
    label_len  = 0;
    held_byte  = 8'd0;
    held_valid = 1'b0;
    ovf_flag   = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_register_extremes();
    test_label_limit();
    test_random_traffic(0, 0, 10);
    test_random_traffic(67, 0, 10);
    test_random_traffic(0, 67, 10);
    test_random_traffic(35, 35, 10);

    $display("covered %0d characters in %0d names, %0d output words, %0d register writes",
             chars_sent, names_sent, words_checked, reg_writes);
    $display("with empty and overlong labels, long names and four idle/stall mixes");
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== dns_query_packet_builder.f =====
+incdir+rtl
rtl/dqpb_pkg.sv
rtl/dqpb_ctrl.sv
rtl/dqpb_datapath.sv
rtl/dqpb_pack.sv
rtl/dns_query_packet_builder.sv
rtl/dqpb_checker.sv
dv/tb_top.sv
